>>> rtl/dsi_pkg.sv
// Shared types, character codes and helper functions for the decimal string
// to int32 converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsi_pkg;

  localparam logic [7:0] CharNul   = 8'd0;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharPlus  = 8'd43;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  localparam logic [1:0] PosLimit = 2'd2;

  localparam logic [35:0] MaxPos = 36'd2147483647;
  localparam logic [35:0] MaxNeg = 36'd2147483648;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
  } stage_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CharSpace, [CharTab:CharCr]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CharZero:CharNine]};
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return c inside {CharPlus, CharMinus};
  endfunction

endpackage

`default_nettype wire

>>> rtl/dsi_if.sv
// Valid/ready channel interfaces: byte input and parsed result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dsi_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dsi_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

`default_nettype wire

>>> rtl/dsi_in_stage.sv
// Input register: captures one byte per transaction and holds it until the
// parser consumes it. Depends on dsi_pkg and dsi_if.
`timescale 1ns / 1ps
`default_nettype none

module dsi_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  dsi_char_if.sink             in_i,
  input  wire logic            advance_i,
  output dsi_pkg::stage_t      stage_o
);
  import dsi_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       load;

  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = in_i.char_code;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.char_code = char_q;

endmodule

`default_nettype wire

>>> rtl/dsi_core.sv
// Parser state and per-byte update: sign, whitespace, digit accumulation and
// range check; offers the result from its state and clears it on the terminator. Depends on dsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsi_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dsi_pkg::stage_t  stage_i,
  input  wire logic             step_i,
  output dsi_pkg::result_t      result_o
);
  import dsi_pkg::*;

  logic [1:0]  pos_q, pos_d;
  logic        first_sign_q, first_sign_d;
  logic        past_space_q, past_space_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic        failed_q, failed_d;

  logic [7:0]  c;
  logic        fail_pre;
  logic        take;
  logic [35:0] mag_ext;
  logic [35:0] mag_next;
  logic [35:0] limit;

  assign c       = stage_i.char_code;
  assign mag_ext = {4'b0, mag_q};
  assign mag_next = (mag_ext << 3) + (mag_ext << 1) + {32'b0, c[3:0]};

  always_comb begin
    pos_d        = pos_q;
    first_sign_d = first_sign_q;
    past_space_d = past_space_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    failed_d     = failed_q;
    fail_pre     = failed_q;
    take         = 1'b0;
    limit        = neg_q ? MaxNeg : MaxPos;

    if (step_i) begin
      if (c == CharNul) begin
        pos_d        = '0;
        first_sign_d = 1'b0;
        past_space_d = 1'b0;
        neg_d        = 1'b0;
        mag_d        = '0;
        failed_d     = 1'b0;
      end else begin
        // signed zero prefix
        if (pos_q == 2'd0) begin
          if (is_sign(c)) first_sign_d = 1'b1;
        end else if (pos_q == 2'd1) begin
          if (first_sign_q && c == CharZero) fail_pre = 1'b1;
        end
        if (pos_q < PosLimit) pos_d = pos_q + 2'd1;
        failed_d = fail_pre;

        if (!past_space_q) begin
          if (!is_space(c)) begin
            past_space_d = 1'b1;
            if (c == CharMinus) begin
              neg_d = 1'b1;
            end else if (c == CharPlus) begin
              neg_d = neg_q;
            end else if (is_digit(c)) begin
              take = 1'b1;
            end else begin
              failed_d = 1'b1;
            end
          end
        end else if (is_digit(c)) begin
          take = 1'b1;
        end else begin
          failed_d = 1'b1;
        end

        if (take && !fail_pre) begin
          if (mag_next > limit) begin
            failed_d = 1'b1;
          end else begin
            mag_d = mag_next[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      first_sign_q <= 1'b0;
      past_space_q <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      failed_q     <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      first_sign_q <= first_sign_d;
      past_space_q <= past_space_d;
      neg_q        <= neg_d;
      mag_q        <= mag_d;
      failed_q     <= failed_d;
    end
  end

  always_comb begin
    result_o.error = failed_q;
    if (failed_q) begin
      result_o.value = '0;
    end else if (neg_q) begin
      result_o.value = $signed(32'd0 - mag_q);
    end else begin
      result_o.value = $signed(mag_q);
    end
  end

`ifndef NO_ASSERTIONS
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= 32'h8000_0000)
    else $error("magnitude above negative limit");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!neg_q) |-> (mag_q <= 32'h7fff_ffff))
    else $error("magnitude above positive limit");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("byte position past saturation");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && c == CharNul) |=>
      (pos_q == 2'd0 && !failed_q && !neg_q && mag_q == 32'd0 && !past_space_q))
    else $error("state not cleared after terminator");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(mag_q) && $stable(failed_q) && $stable(pos_q)))
    else $error("state changed without a step");
`endif

endmodule

`default_nettype wire

>>> rtl/decimal_string_to_int32.sv
// Decimal string to int32 converter: takes one byte per cycle and, on each
// zero terminator, returns the signed 32-bit value and an error flag. A
// byte passes an input register, then the parser updates its state; when
// the parser steps on a terminator, that step loads the result register,
// which offers the result on the output channel. Throughput is one byte per
// cycle; a terminator waits in the input register only while the
// previous result is still held untaken in the result register. Leading
// whitespace, one sign, digits; sticky errors ('+0'/'-0' prefix, stray
// bytes, overflow) give value 0 with error set. An empty string or a lone
// sign gives 0, no error.
// Depends on dsi_pkg, dsi_if, dsi_in_stage and dsi_core.
`timescale 1ns / 1ps
`default_nettype none

module decimal_string_to_int32 (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dsi_char_if.sink    in_i,
  dsi_result_if.source out_o
);
  import dsi_pkg::*;

  stage_t  stage;
  result_t result;
  logic    out_free;
  logic    step;
  logic    term_step;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  assign out_free  = !out_valid_q || out_o.ready;
  assign step      = stage.valid && ((stage.char_code != CharNul) || out_free);
  assign term_step = step && (stage.char_code == CharNul);

  dsi_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (step),
    .stage_o   (stage)
  );

  dsi_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .step_i   (step),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (term_step) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_q.value;
  assign out_o.error = out_q.error;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Testbench for decimal_string_to_int32: drives byte strings through the
// valid/ready input and checks each parsed value and error flag in order.
// Depends on dsi_pkg, dsi_if and the decimal_string_to_int32 RTL.
`timescale 1ns / 1ps

module testbench;
  import dsi_pkg::*;

  localparam int IdleLimit   = 400;
  localparam int RandomBytes = 920;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dsi_char_if   char_ch ();
  dsi_result_if res_ch ();

  decimal_string_to_int32 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_ch),
    .out_o (res_ch)
  );

  // parser image
  logic [1:0]  p_pos;
  logic        p_lead_sign;
  logic        p_started;
  logic        p_neg;
  logic [31:0] p_mag;
  logic        p_failed;

  result_t     parsed_q[$];
  logic [7:0]  str_buf[$];

  logic src_steady = 1'b0;
  logic snk_steady = 1'b0;
  int   fail_count = 0;
  int   bytes_sent = 0;
  int   strings_sent = 0;
  int   results_seen = 0;
  int   error_results = 0;
  int   idle_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic clear_parser();
    p_pos       = '0;
    p_lead_sign = 1'b0;
    p_started   = 1'b0;
    p_neg       = 1'b0;
    p_mag       = '0;
    p_failed    = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic        use_digit;
    logic        is_num;
    logic [35:0] nxt;
    logic [35:0] lim;
    result_t     r;
    if (c == CharNul) begin
      r.error = p_failed;
      r.value = p_failed ? 32'sd0 : (p_neg ? 32'd0 - p_mag : p_mag);
      parsed_q.push_back(r);
      clear_parser();
      return;
    end
    is_num = (c >= CharZero) && (c <= CharNine);
    if (p_pos == 2'd0) begin
      if (c == CharPlus || c == CharMinus) p_lead_sign = 1'b1;
    end else if (p_pos == 2'd1) begin
      if (p_lead_sign && c == CharZero) p_failed = 1'b1;
    end
    if (p_pos < PosLimit) p_pos = p_pos + 2'd1;
    use_digit = 1'b0;
    if (!p_started) begin
      if (!(c == CharSpace || (c >= CharTab && c <= CharCr))) begin
        p_started = 1'b1;
        if (c == CharMinus) begin
          p_neg = 1'b1;
        end else if (c != CharPlus) begin
          if (is_num) use_digit = 1'b1;
          else p_failed = 1'b1;
        end
      end
    end else if (is_num) begin
      use_digit = 1'b1;
    end else begin
      p_failed = 1'b1;
    end
    if (use_digit && !p_failed) begin
      nxt = {4'd0, p_mag} * 36'd10 + {28'd0, c - CharZero};
      lim = p_neg ? MaxNeg : MaxPos;
      if (nxt > lim) p_failed = 1'b1;
      else p_mag = nxt[31:0];
    end
  endtask

  initial clear_parser();

  always @(posedge clk_i) begin
    if (rst_ni && char_ch.valid && char_ch.ready) parse_char(char_ch.char_code);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.error) error_results++;
      if (parsed_q.size() == 0) begin
        $error("unexpected result: value %0d error %0b", res_ch.value, res_ch.error);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        if (res_ch.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, res_ch.value);
          fail_count++;
        end
        if (res_ch.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, res_ch.error);
          fail_count++;
        end
      end
    end
  end

  // result sink with random backpressure
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 9) == 0) snk_steady = !snk_steady;
      stall = snk_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(negedge clk_i);
      while (!res_ch.valid) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $error("no transaction for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    @(negedge clk_i);
    while (!char_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_string();
    src_steady = ($urandom_range(0, 5) == 0);
    foreach (str_buf[i]) send_char(str_buf[i]);
    send_char(CharNul);
    str_buf.delete();
    strings_sent++;
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) str_buf.push_back(s[i]);
  endtask

  task automatic put_number(input longint unsigned n);
    put_text($sformatf("%0d", n));
  endtask

  task automatic put_sign(input int s);
    if (s == 1) str_buf.push_back(CharPlus);
    else if (s == 2) str_buf.push_back(CharMinus);
  endtask

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(8, 13);
    return (k == 8) ? CharSpace : 8'(k);
  endfunction

  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic build_number();
    int               r;
    longint unsigned  n;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) str_buf.push_back(pick_space());
    put_sign($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) str_buf.push_back(CharZero);
    r = $urandom_range(0, 9);
    if (r <= 3) n = $urandom_range(0, 999);
    else if (r <= 5) n = $urandom;
    else if (r <= 7) n = 64'd2147483638 + $urandom_range(0, 20);
    else if (r == 8) n = {$urandom, $urandom} % 64'd1000000000000;
    else n = $urandom_range(0, 9);
    put_number(n);
  endtask

  task automatic test_special_cases();
    send_string();
    put_text("-0");
    send_string();
    put_text("+");
    send_string();
    str_buf.push_back(CharCr);
    put_text("-5");
    send_string();
    put_text("1 ");
    send_string();
    put_text("5+");
    send_string();
    str_buf.push_back(8'hFF);
    send_string();
    put_text("+7");
    send_string();
    str_buf.push_back(CharSpace);
    str_buf.push_back(CharTab);
    send_string();
  endtask

  task automatic test_range_limits();
    for (int s = 0; s < 3; s++) begin
      for (longint unsigned m = 2147483645; m <= 2147483650; m++) begin
        put_sign(s);
        put_number(m);
        send_string();
      end
    end
    put_number(64'd4294967295);
    send_string();
    put_sign(2);
    put_number(64'd9999999999);
    send_string();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      build_number();
      send_string();
    end
    wait_drained();
    repeat (4) begin
      build_number();
      send_string();
    end
  endtask

  task automatic test_random_strings();
    int start_bytes;
    int kind;
    int idx;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandomBytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) build_number();
      if (kind >= 70 && kind < 85) begin
        idx = $urandom_range(0, str_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: str_buf[idx] = 8'($urandom_range(1, 255));
          1: str_buf.insert(idx, pick_space());
          default: str_buf.insert(idx, $urandom_range(0, 1) ? CharPlus : CharMinus);
        endcase
      end else if (kind >= 85) begin
        repeat ($urandom_range(0, 6)) str_buf.push_back(8'($urandom_range(1, 255)));
      end
      send_string();
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  initial begin
    char_ch.valid     <= 1'b0;
    char_ch.char_code <= CharNul;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_range_limits();
    test_drain_pause();
    test_random_strings();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (parsed_q.size() != 0) begin
      $error("%0d results never arrived", parsed_q.size());
      fail_count += parsed_q.size();
    end
    $display("Sent %0d strings (%0d bytes): signs, whitespace, limits, stray bytes.",
             strings_sent, bytes_sent);
    $display("Checked %0d results, %0d flagged as errors; %0d mismatches.",
             results_seen, error_results, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
